// ----- sv/flood_forward_dedup_filter_macros.svh -----
// Assertion helpers shared by the filter modules.
`ifndef FLOOD_FORWARD_DEDUP_FILTER_MACROS_SVH
`define FLOOD_FORWARD_DEDUP_FILTER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define FFDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define FFDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ffdf_pkg.sv -----
`default_nettype none

package ffdf_pkg;

    localparam int HISTORY_DEPTH = 20;

    localparam int ID_W    = 32;
    localparam int TTL_W   = 8;
    localparam int TAG_W   = 2;
    localparam int ACT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [ID_W-1:0]  HIST_RESET_ID  = ID_W'(9999999);
    localparam logic [TTL_W-1:0] SEND_TTL       = TTL_W'(100);
    localparam logic [TTL_W-1:0] ROUTER_TTL_CAP = TTL_W'(10);

    // result actions
    localparam logic [ACT_W-1:0] ACT_DUP_DROP  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELIVER   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FORWARD   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NOT_FWD   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TTL_EXPIRED = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SEND      = 3'd5;

    // node roles
    localparam logic [1:0] NODE_SENSOR = 2'd0;
    localparam logic [1:0] NODE_ROUTER = 2'd1;
    localparam logic [1:0] NODE_IFACE  = 2'd2;

    // role tags carried in headers
    localparam logic [TAG_W-1:0] TAG_NONE   = 2'd0;
    localparam logic [TAG_W-1:0] TAG_SENSOR = 2'd1;
    localparam logic [TAG_W-1:0] TAG_ROUTER = 2'd2;

    // request kinds
    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_MSG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 2'd2;

    // one history slot as it moves down the chain
    typedef struct packed {
        logic            vld;
        logic [ID_W-1:0] id;
    } t_link;

    typedef logic [HISTORY_DEPTH-1:0] t_vld_vec;

endpackage

`default_nettype wire

// ----- sv/ffdf_cell.sv -----
`default_nettype none

// One history slot: loads its upstream neighbor on a push, compares against the key.
module ffdf_cell
    import ffdf_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire t_link           i_prev,
    input  wire logic [ID_W-1:0] i_key,
    output t_link                o_link,
    output logic                 o_hit
);

    t_link r_link;
    t_link n_link;

    always_comb begin
        n_link = r_link;
        if (i_shift) begin
            n_link = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.vld <= 1'b0;
            r_link.id  <= HIST_RESET_ID;
        end else begin
            r_link <= n_link;
        end
    end

    // an empty slot never matches
    assign o_hit  = r_link.vld && (r_link.id == i_key);
    assign o_link = r_link;

endmodule

`default_nettype wire

// ----- sv/ffdf_history.sv -----
`default_nettype none

// Duplicate-id history as a shift chain of cells; head takes the newest id.
module ffdf_history
    import ffdf_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic [ID_W-1:0] i_id,
    output logic                 o_hit
);

`include "flood_forward_dedup_filter_macros.svh"

    t_link    links [HISTORY_DEPTH+1];
    t_vld_vec hits;
    t_vld_vec vlds;

    assign links[0] = '{vld: 1'b1, id: i_id};

    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        ffdf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_push),
            .i_prev  (links[g]),
            .i_key   (i_id),
            .o_link  (links[g+1]),
            .o_hit   (hits[g])
        );
        assign vlds[g] = links[g+1].vld;
    end

    assign o_hit = |hits;

    // newest id lands in the head cell
    `FFDF_ASSERT_NEXT(a_head_load, i_clk, i_rst_n, i_push, links[1].vld && (links[1].id == $past(i_id)), "history head not loaded")
    // filled cells are contiguous from the head
    `FFDF_ASSERT_NOW(a_fill_contig, i_clk, i_rst_n, 1'b1, (vlds & (vlds + 1'b1)) == '0, "history fill has a gap")

endmodule

`default_nettype wire

// ----- sv/flood_forward_dedup_filter.sv -----
`default_nettype none

// Flooding forwarder with duplicate suppression. Each input transaction is either a
// header received from the radio or a local send. Received headers are matched
// against the last 20 packet ids (a shift chain of cells, one comparator per cell,
// all matched in parallel) and then pushed into that history, duplicates included;
// local sends push without a match. A new header is delivered locally by an
// interface with a message unit, else forwarded when the sender was a sensor or both
// sender and node are routers, provided TTL > 1. Dropped results carry zero fields.
// Throughput is one transaction per cycle: the match plus the action decision fit in
// the cycle that takes the transaction, and an output register captures the result as
// that cycle ends. The input stalls only while that register holds a result not yet taken.
// Configuration writes (index 0 node type, 1 message unit present, 2 node id) are
// always accepted and are meant to happen while the block is idle; index 3 is ignored.
module flood_forward_dedup_filter
    import ffdf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,

    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_req_type,
    input  wire logic [ID_W-1:0]      i_packet_id,
    input  wire logic [TTL_W-1:0]     i_in_ttl,
    input  wire logic [TAG_W-1:0]     i_sender_type,
    input  wire logic [ID_W-1:0]      i_src_addr,

    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [ACT_W-1:0]          o_action,
    output logic [TTL_W-1:0]          o_out_ttl,
    output logic [TAG_W-1:0]          o_out_sender_type,
    output logic [ID_W-1:0]           o_out_source,
    output logic [ID_W-1:0]           o_out_packet_id
);

`include "flood_forward_dedup_filter_macros.svh"

    // configuration
    logic [1:0]       r_node_type;
    logic             r_has_msg;
    logic [ID_W-1:0]  r_node_id;

    // output register
    logic             r_out_valid;
    logic [ACT_W-1:0] r_action;
    logic [TTL_W-1:0] r_ttl;
    logic [TAG_W-1:0] r_tag;
    logic [ID_W-1:0]  r_source;
    logic [ID_W-1:0]  r_pkt_id;

    logic             n_out_valid;
    logic [ACT_W-1:0] n_action;
    logic [TTL_W-1:0] n_ttl;
    logic [TAG_W-1:0] n_tag;
    logic [ID_W-1:0]  n_source;
    logic [ID_W-1:0]  n_pkt_id;

    logic             in_accept;
    logic             cfg_accept;
    logic             dup_hit;
    logic [TAG_W-1:0] own_tag;
    logic [TTL_W-1:0] ttl_dec;
    logic [TTL_W-1:0] fwd_ttl;
    logic             fwd_ok;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;

    // output register frees up in the same cycle it is drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // history is matched before this transaction's push lands
    ffdf_history u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_id    (i_packet_id),
        .o_hit   (dup_hit)
    );

    always_comb begin
        unique case (r_node_type)
            NODE_SENSOR: own_tag = TAG_SENSOR;
            NODE_ROUTER: own_tag = TAG_ROUTER;
            default:     own_tag = TAG_NONE;
        endcase
    end

    assign ttl_dec = i_in_ttl - 1'b1;

    always_comb begin
        unique case (r_node_type)
            NODE_SENSOR: fwd_ttl = ttl_dec;
            NODE_ROUTER: fwd_ttl = (ttl_dec > ROUTER_TTL_CAP) ? ROUTER_TTL_CAP : ttl_dec;
            default:     fwd_ttl = i_in_ttl;
        endcase
    end

    // sensor traffic always floods; router traffic only between routers
    assign fwd_ok = (i_sender_type == TAG_SENSOR)
                 || ((i_sender_type == TAG_ROUTER) && (r_node_type == NODE_ROUTER));

    always_comb begin
        n_action = ACT_DUP_DROP;
        n_ttl    = '0;
        n_tag    = TAG_NONE;
        n_source = '0;
        n_pkt_id = '0;
        priority if (i_req_type == REQ_SEND) begin
            n_action = ACT_SEND;
            n_ttl    = SEND_TTL;
            n_tag    = own_tag;
            n_source = r_node_id;
            n_pkt_id = i_packet_id;
        end else if (dup_hit) begin
            n_action = ACT_DUP_DROP;
        end else if (r_has_msg && (r_node_type == NODE_IFACE)) begin
            n_action = ACT_DELIVER;
            n_ttl    = i_in_ttl;
            n_source = i_src_addr;
            n_pkt_id = i_packet_id;
        end else if (fwd_ok) begin
            if (i_in_ttl > TTL_W'(1)) begin
                n_action = ACT_FORWARD;
                n_ttl    = fwd_ttl;
                n_tag    = own_tag;
                n_source = i_src_addr;
                n_pkt_id = i_packet_id;
            end else begin
                n_action = ACT_TTL_EXPIRED;
            end
        end else begin
            n_action = ACT_NOT_FWD;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_node_type <= NODE_SENSOR;
            r_has_msg   <= 1'b0;
            r_node_id   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (cfg_accept) begin
                unique case (i_cfg_index)
                    CFG_NODE_TYPE: r_node_type <= i_cfg_data[1:0];
                    CFG_HAS_MSG:   r_has_msg   <= i_cfg_data[0];
                    CFG_NODE_ID:   r_node_id   <= i_cfg_data[ID_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= n_action;
            r_ttl    <= n_ttl;
            r_tag    <= n_tag;
            r_source <= n_source;
            r_pkt_id <= n_pkt_id;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_action          = r_action;
    assign o_out_ttl         = r_ttl;
    assign o_out_sender_type = r_tag;
    assign o_out_source      = r_source;
    assign o_out_packet_id   = r_pkt_id;

    // every accepted transaction produces a result
    `FFDF_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, in_accept, r_out_valid, "accepted transaction left no result")
    // drops carry empty header fields
    `FFDF_ASSERT_NOW(a_drop_zero, i_clk, i_rst_n, r_out_valid && ((r_action == ACT_DUP_DROP) || (r_action == ACT_NOT_FWD) || (r_action == ACT_TTL_EXPIRED)), (r_ttl == '0) && (r_tag == TAG_NONE) && (r_source == '0) && (r_pkt_id == '0), "drop result has nonzero fields")
    // router forwards stay within the cap and never carry a dead TTL
    `FFDF_ASSERT_NOW(a_router_cap, i_clk, i_rst_n, r_out_valid && (r_action == ACT_FORWARD) && (r_tag == TAG_ROUTER), (r_ttl <= ROUTER_TTL_CAP) && (r_ttl != '0), "router forward TTL out of range")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffdf_pkg::*;

    // Codes the package leaves unnamed but the ports can carry.
    localparam logic [1:0]           NODE_OTHER = 2'd3;  // role outside the three known ones
    localparam logic [TAG_W-1:0]     TAG_BAD    = 2'd3;  // sender tag outside the known ones
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;  // unused register slot

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_IDLE     = 11;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 188;   // about 1500 random headers overall
    localparam int HOLD_CYCLES  = 250;

    // One request as offered on the input channel, plus the idle gap before it.
    typedef struct {
        logic             kind;
        logic [ID_W-1:0]  id;
        logic [TTL_W-1:0] ttl;
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  src;
        int unsigned      gap;
    } t_hdr_req;

    // One outgoing decision, field for field as on the output ports.
    typedef struct {
        logic [ACT_W-1:0] act;
        logic [TTL_W-1:0] ttl;
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  src;
        logic [ID_W-1:0]  id;
    } t_hdr_res;

    // ------------------------------------------------------------------
    // DUT ports. Everything starts at a known value.
    // ------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic                 i_req_type    = REQ_RX;
    logic [ID_W-1:0]      i_packet_id   = '0;
    logic [TTL_W-1:0]     i_in_ttl      = '0;
    logic [TAG_W-1:0]     i_sender_type = '0;
    logic [ID_W-1:0]      i_src_addr    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [ACT_W-1:0]     o_action;
    logic [TTL_W-1:0]     o_out_ttl;
    logic [TAG_W-1:0]     o_out_sender_type;
    logic [ID_W-1:0]      o_out_source;
    logic [ID_W-1:0]      o_out_packet_id;

    flood_forward_dedup_filter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_packet_id       (i_packet_id),
        .i_in_ttl          (i_in_ttl),
        .i_sender_type     (i_sender_type),
        .i_src_addr        (i_src_addr),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_action          (o_action),
        .o_out_ttl         (o_out_ttl),
        .o_out_sender_type (o_out_sender_type),
        .o_out_source      (o_out_source),
        .o_out_packet_id   (o_out_packet_id)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_hdr_req    header_q [$];      // headers waiting to be offered
    t_hdr_res    decision_q [$];    // predicted decisions, oldest first
    t_hdr_req    cur_hdr;
    logic        have_item = 1'b0;  // driver holds a taken header not yet on the bus
    int unsigned snd_gap_max = 0;
    int unsigned rcv_gap_max = 0;
    int unsigned fails = 0;
    int unsigned hdrs_taken = 0;
    int unsigned res_checked = 0;
    int unsigned act_count [8];
    logic [ID_W-1:0] id_pool [$];   // recently generated ids, feeds duplicates

    // Predictor copy of the duplicate history and the node configuration.
    logic [ID_W-1:0] hist_id  [HISTORY_DEPTH];
    logic            hist_vld [HISTORY_DEPTH];
    int unsigned     hist_wr;
    logic [1:0]      node_role;
    logic            msg_unit;
    logic [ID_W-1:0] own_id;

    // ------------------------------------------------------------------
    // Flooding predictor
    // ------------------------------------------------------------------
    function automatic logic [TAG_W-1:0] own_tag();
        case (node_role)
            NODE_SENSOR: return TAG_SENSOR;
            NODE_ROUTER: return TAG_ROUTER;
            default:     return TAG_NONE;   // interface and the unnamed role
        endcase
    endfunction

    // History is a ring: newest id overwrites the oldest slot.
    function automatic void remember_id(logic [ID_W-1:0] id);
        hist_id[hist_wr]  = id;
        hist_vld[hist_wr] = 1'b1;
        hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
    endfunction

    // Decision for one header; updates the history as a side effect.
    function automatic t_hdr_res route_header(t_hdr_req rq);
        t_hdr_res         r;
        logic             seen;
        logic [TTL_W-1:0] t;
        r    = '{default: '0};
        seen = 1'b0;
        if (rq.kind == REQ_SEND) begin
            // local send: no duplicate check, fresh header
            remember_id(rq.id);
            r.act = ACT_SEND;
            r.ttl = SEND_TTL;
            r.tag = own_tag();
            r.src = own_id;
            r.id  = rq.id;
            return r;
        end
        // slots never written hold the reset id but must not match
        for (int i = 0; i < HISTORY_DEPTH; i++)
            if (hist_vld[i] && hist_id[i] == rq.id)
                seen = 1'b1;
        remember_id(rq.id);   // duplicates are pushed again
        if (seen) begin
            r.act = ACT_DUP_DROP;
        end else if (msg_unit && node_role == NODE_IFACE) begin
            r.act = ACT_DELIVER;
            r.ttl = rq.ttl;
            r.src = rq.src;
            r.id  = rq.id;
        end else if (rq.tag == TAG_SENSOR
                     || (rq.tag == TAG_ROUTER && node_role == NODE_ROUTER)) begin
            if (rq.ttl > 1) begin
                t = rq.ttl;
                if (node_role == NODE_SENSOR) begin
                    t = rq.ttl - TTL_W'(1);
                end else if (node_role == NODE_ROUTER) begin
                    t = rq.ttl - TTL_W'(1);
                    if (t > ROUTER_TTL_CAP)
                        t = ROUTER_TTL_CAP;
                end
                r.act = ACT_FORWARD;
                r.ttl = t;
                r.tag = own_tag();
                r.src = rq.src;
                r.id  = rq.id;
            end else begin
                r.act = ACT_TTL_EXPIRED;
            end
        end else begin
            r.act = ACT_NOT_FWD;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic t_hdr_req mk_req(logic kind, logic [ID_W-1:0] id, logic [TTL_W-1:0] ttl,
                                        logic [TAG_W-1:0] tag, logic [ID_W-1:0] src);
        t_hdr_req rq;
        rq.kind = kind;
        rq.id   = id;
        rq.ttl  = ttl;
        rq.tag  = tag;
        rq.src  = src;
        rq.gap  = $urandom_range(0, snd_gap_max);
        return rq;
    endfunction

    // Appends one header to the driver's pending list.
    function automatic void queue_hdr(t_hdr_req rq);
        header_q.insert(header_q.size(), rq);
    endfunction

    // Mostly well-formed traffic; about 40% reuses a recent id so duplicates
    // land both inside and just outside the 20-deep window.
    function automatic t_hdr_req rand_req();
        int unsigned      pick;
        int unsigned      tsel;
        int unsigned      gsel;
        logic [ID_W-1:0]  id;
        logic [TTL_W-1:0] ttl;
        logic [TAG_W-1:0] tag;
        pick = $urandom_range(0, 99);
        if (id_pool.size() > 0 && pick < 40)
            id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else if (pick < 44)
            id = HIST_RESET_ID;
        else if (pick < 60)
            id = $urandom_range(0, 63);
        else
            id = $urandom;
        id_pool.insert(id_pool.size(), id);
        if (id_pool.size() > 26)
            id_pool.delete(0);

        tsel = $urandom_range(0, 9);
        case (tsel)
            0:       ttl = 8'd0;
            1:       ttl = 8'd1;
            2:       ttl = 8'd2;
            3:       ttl = 8'd11;
            4:       ttl = 8'd12;
            5:       ttl = 8'hFF;
            default: ttl = TTL_W'($urandom_range(0, 255));
        endcase

        gsel = $urandom_range(0, 9);
        if (gsel == 0)      tag = TAG_NONE;
        else if (gsel == 1) tag = TAG_BAD;
        else if (gsel < 6)  tag = TAG_SENSOR;
        else                tag = TAG_ROUTER;

        return mk_req(($urandom_range(0, 99) < 15) ? REQ_SEND : REQ_RX, id, ttl, tag, $urandom);
    endfunction

    // ------------------------------------------------------------------
    // Configuration channel, driven from the sequence below, only when idle
    // ------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Upper data bits are random so the register masking gets exercised too.
    task automatic set_node(logic [1:0] role, logic msg, logic [ID_W-1:0] nid);
        cfg_write(CFG_NODE_TYPE, ($urandom & ~32'h3) | CFG_DAT_W'(role));
        cfg_write(CFG_HAS_MSG, ($urandom & ~32'h1) | CFG_DAT_W'(msg));
        cfg_write(CFG_NODE_ID, nid);
        cfg_write(CFG_SPARE, $urandom);   // must be ignored
    endtask

    // Wait until every header is offered and every decision has come back.
    task automatic drain();
        do @(negedge i_clk);
        while (header_q.size() != 0 || have_item || i_in_valid || decision_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: takes headers off the list, waits out each one's gap,
    // then holds valid and the payload steady until the transaction is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (!have_item && header_q.size() != 0) begin
                cur_hdr   = header_q[0];
                header_q.delete(0);
                have_item = 1'b1;
            end
            if (have_item && cur_hdr.gap == 0) begin
                i_in_valid    <= 1'b1;
                i_req_type    <= cur_hdr.kind;
                i_packet_id   <= cur_hdr.id;
                i_in_ttl      <= cur_hdr.ttl;
                i_sender_type <= cur_hdr.tag;
                i_src_addr    <= cur_hdr.src;
                have_item = 1'b0;
            end else begin
                i_in_valid <= 1'b0;
                if (have_item)
                    cur_hdr.gap--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: random stall after each taken result, plus two long
    // hold-offs so the output register fills and the input backs up.
    // ------------------------------------------------------------------
    int unsigned out_wait  = 0;
    int unsigned hold_left = 0;
    int unsigned outs_seen = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                outs_seen++;
                out_wait = $urandom_range(0, rcv_gap_max);
                if (outs_seen == 400 || outs_seen == 1100)
                    hold_left = HOLD_CYCLES;
            end else if (!i_out_ready) begin
                if (hold_left > 0)
                    hold_left--;
                else if (out_wait > 0)
                    out_wait--;
            end
            i_out_ready <= (hold_left == 0 && out_wait == 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: tracks config writes, predicts on every accepted header and
    // checks every accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_hdr_req taken;
        t_hdr_res want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NODE_TYPE: node_role = i_cfg_data[1:0];
                    CFG_HAS_MSG:   msg_unit  = i_cfg_data[0];
                    CFG_NODE_ID:   own_id    = i_cfg_data;
                    default:       ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                taken.kind = i_req_type;
                taken.id   = i_packet_id;
                taken.ttl  = i_in_ttl;
                taken.tag  = i_sender_type;
                taken.src  = i_src_addr;
                taken.gap  = 0;
                decision_q.insert(decision_q.size(), route_header(taken));
                hdrs_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (decision_q.size() == 0) begin
                    $error("result with no header pending: action %0d id 0x%0h",
                           o_action, o_out_packet_id);
                    fails++;
                end else begin
                    want = decision_q[0];
                    decision_q.delete(0);
                    check_field("action", ID_W'(want.act), ID_W'(o_action));
                    check_field("out_ttl", ID_W'(want.ttl), ID_W'(o_out_ttl));
                    check_field("out_sender_type", ID_W'(want.tag),
                                ID_W'(o_out_sender_type));
                    check_field("out_source", want.src, o_out_source);
                    check_field("out_packet_id", want.id, o_out_packet_id);
                    res_checked++;
                    act_count[o_action]++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned mode;
        logic [ID_W-1:0] nid;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_id[i]  = HIST_RESET_ID;
            hist_vld[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            act_count[i] = 0;
        hist_wr   = 0;
        node_role = NODE_SENSOR;
        msg_unit  = 1'b0;
        own_id    = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset config is a sensor without a message unit.
        snd_gap_max = 3;
        rcv_gap_max = 3;
        // the reset id must not look like a duplicate while slots are empty
        queue_hdr(mk_req(REQ_RX, HIST_RESET_ID, 8'd5, TAG_SENSOR, 32'h0));
        queue_hdr(mk_req(REQ_RX, HIST_RESET_ID, 8'd5, TAG_SENSOR, 32'h0));
        queue_hdr(mk_req(REQ_RX, 32'h0, 8'hFF, TAG_SENSOR, 32'hFFFF_FFFF));
        queue_hdr(mk_req(REQ_RX, 32'hFFFF_FFFF, 8'd1, TAG_SENSOR, 32'h1234_5678));
        queue_hdr(mk_req(REQ_RX, 32'd1, 8'd0, TAG_SENSOR, 32'h1));
        queue_hdr(mk_req(REQ_RX, 32'd2, 8'd2, TAG_ROUTER, 32'h2));
        queue_hdr(mk_req(REQ_RX, 32'd3, 8'd9, TAG_NONE, 32'h3));
        queue_hdr(mk_req(REQ_RX, 32'd4, 8'd9, TAG_BAD, 32'h4));
        queue_hdr(mk_req(REQ_SEND, 32'd7, 8'hFF, TAG_BAD, 32'hFFFF_FFFF));
        queue_hdr(mk_req(REQ_RX, 32'd7, 8'd9, TAG_SENSOR, 32'h5));   // sent id is known
        drain();

        // Router: TTL cap around 10, router-to-router forwarding.
        set_node(NODE_ROUTER, 1'b1, 32'hFFFF_FFFF);
        queue_hdr(mk_req(REQ_RX, 32'd10, 8'hFF, TAG_ROUTER, 32'hA));
        queue_hdr(mk_req(REQ_RX, 32'd11, 8'd12, TAG_SENSOR, 32'hB));
        queue_hdr(mk_req(REQ_RX, 32'd12, 8'd11, TAG_ROUTER, 32'hC));
        queue_hdr(mk_req(REQ_RX, 32'd13, 8'd10, TAG_ROUTER, 32'hD));
        queue_hdr(mk_req(REQ_RX, 32'd14, 8'd2, TAG_ROUTER, 32'hE));
        queue_hdr(mk_req(REQ_RX, 32'd15, 8'd0, TAG_NONE, 32'hF));
        queue_hdr(mk_req(REQ_SEND, 32'd16, 8'd0, TAG_NONE, 32'h0));
        drain();

        // Interface with a message unit: local delivery of new headers.
        set_node(NODE_IFACE, 1'b1, 32'h5A5A_A5A5);
        queue_hdr(mk_req(REQ_RX, 32'd20, 8'd0, TAG_NONE, 32'hCAFE_0001));
        queue_hdr(mk_req(REQ_RX, 32'd20, 8'd0, TAG_NONE, 32'hCAFE_0001));
        queue_hdr(mk_req(REQ_RX, 32'd21, 8'hFF, TAG_ROUTER, 32'hCAFE_0002));
        queue_hdr(mk_req(REQ_SEND, 32'd22, 8'd3, TAG_SENSOR, 32'h0));
        drain();

        // Interface without one: sensor traffic goes on with TTL unchanged.
        set_node(NODE_IFACE, 1'b0, 32'h0F0F_F0F0);
        queue_hdr(mk_req(REQ_RX, 32'd30, 8'd7, TAG_SENSOR, 32'h30));
        queue_hdr(mk_req(REQ_RX, 32'd31, 8'd7, TAG_ROUTER, 32'h31));
        drain();

        // Unnamed role with a message unit: never delivers locally.
        set_node(NODE_OTHER, 1'b1, 32'h8000_0001);
        queue_hdr(mk_req(REQ_RX, 32'd40, 8'd6, TAG_SENSOR, 32'h40));
        queue_hdr(mk_req(REQ_RX, 32'd41, 8'd6, TAG_ROUTER, 32'h41));
        drain();

        // Random phases: every role with and without a message unit, mixed
        // idle patterns including stretches with no idling at all.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode = (ph + 1) % 4;
            snd_gap_max = (mode == 0 || mode == 3) ? MAX_IDLE : 0;
            rcv_gap_max = (mode == 0 || mode == 2) ? MAX_IDLE : 0;
            if (ph == 0)      nid = 32'h0;
            else if (ph == 1) nid = 32'hFFFF_FFFF;
            else              nid = $urandom;
            set_node(2'(ph % 4), 1'(ph / 4), nid);
            for (int k = 0; k < PHASE_ITEMS; k++)
                queue_hdr(rand_req());
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d headers over %0d node settings, %0d decisions checked, %0d errors",
                 hdrs_taken, RAND_PHASES + 5, res_checked, fails);
        $display("decisions: dup %0d deliver %0d forward %0d not-fwd %0d expired %0d sent %0d",
                 act_count[ACT_DUP_DROP], act_count[ACT_DELIVER], act_count[ACT_FORWARD],
                 act_count[ACT_NOT_FWD], act_count[ACT_TTL_EXPIRED], act_count[ACT_SEND]);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("status: fail");
        $finish;
    end

endmodule
